@@ src/cctp_pkg.sv @@
// Shared types and codes for the call-context time profiler.
// Used by the top level, the shared ALU and the port checker.
package cctp_pkg;

  localparam int STAMP_W = 16;
  localparam logic [STAMP_W-1:0] STAMP_MASK = 16'hffff;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TREE_FULL     = 3'd1,
    ST_CHILDREN_FULL = 3'd2,
    ST_POP_ROOT      = 3'd3,
    ST_BAD_INDEX     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_EQ  = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        eq;
  } alu_rsp_t;

endpackage

@@ src/call_context_time_profiler.sv @@
// Call-context time profiler: sequencer, node memories and result register.
// Depends on cctp_pkg, cctp_ram and cctp_alu.
//
// One event is offered on operation/tag/timestamp/node_index with item_valid;
// it transfers when item_stall is low. Each event returns exactly one result
// on current_node..read_child_count, which transfers when result_valid is high
// and result_stall is low.
// The block handles one event at a time and stalls the input until the event
// has been written to the result register. A push searches the child list,
// one child entry read and compared per cycle on the shared ALU, and takes
// extra steps when the tree or child list is full and when a node is created.
// The result register loads at the edge where the input reopens. A finished
// result waits in the output register while a new event is taken; if the
// receiver stalls, the next result is held in the sequencer until the register
// frees. Node memories are not cleared; a fill count marks live nodes. After
// reset the input is stalled while the root entry is written; the tree then
// holds the root alone and the last timestamp is zero.
module call_context_time_profiler #(
  parameter int MAX_NODES    = 64,
  parameter int MAX_CHILDREN = 8,
  parameter int TAG_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] tag,
  input  logic [15:0] timestamp,
  input  logic [5:0]  node_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [5:0]  current_node,
  output logic [2:0]  status,
  output logic [6:0]  node_count,
  output logic [31:0] read_total,
  output logic [15:0] read_tag,
  output logic [5:0]  read_parent,
  output logic [3:0]  read_child_count
);

  localparam int NODE_W   = $clog2(MAX_NODES);
  localparam int ALLOC_W  = $clog2(MAX_NODES + 1);
  localparam int CNT_W    = $clog2(MAX_CHILDREN + 1);
  localparam int SLOT_W   = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int CH_DEPTH = MAX_NODES * (2 ** SLOT_W);
  localparam int TAG_W    = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int CH_W     = NODE_W + TAG_W;
  localparam int CMP_W    = (ALLOC_W > 6) ? ALLOC_W : 6;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DELTA,
    S_CHARGE,
    S_SEARCH,
    S_ALLOC,
    S_ALLOC2,
    S_RD_ADDR,
    S_RD_DATA,
    S_CLEAR,
    S_OUT
  } state_t;

  state_t                 state;
  cctp_pkg::op_t          op_q;
  logic [TAG_W-1:0]       tag_q;
  logic [15:0]            stamp_q;
  logic [5:0]             idx_q;
  logic [NODE_W-1:0]      cur;
  logic [ALLOC_W-1:0]     alloc;
  logic [15:0]            last_stamp;
  logic [15:0]            delta_q;
  logic [31:0]            total_q;
  logic [CNT_W-1:0]       n_q;
  logic [NODE_W-1:0]      parent_q;
  logic [CNT_W-1:0]       srch_i;
  cctp_pkg::status_t      res_status;
  logic [31:0]            res_total;
  logic [TAG_W-1:0]       res_tag;
  logic [NODE_W-1:0]      res_parent;
  logic [CNT_W-1:0]       res_count;

  // memory ports
  logic                   tot_we, cnt_we, par_we, tag_we, ch_we;
  logic [NODE_W-1:0]      tot_waddr, tot_raddr, cnt_waddr, cnt_raddr;
  logic [NODE_W-1:0]      par_waddr, par_raddr, tag_waddr, tag_raddr;
  logic [NODE_W+SLOT_W-1:0] ch_waddr, ch_raddr;
  logic [31:0]            tot_wdata, tot_rdata;
  logic [CNT_W-1:0]       cnt_wdata, cnt_rdata;
  logic [NODE_W-1:0]      par_wdata, par_rdata;
  logic [TAG_W-1:0]       tag_wdata, tag_rdata;
  logic [CH_W-1:0]        ch_wdata, ch_rdata;

  cctp_pkg::alu_req_t     alu_req;
  cctp_pkg::alu_rsp_t     alu_rsp;

  logic [NODE_W-1:0]      new_node;
  logic [NODE_W-1:0]      idx_node;
  logic [NODE_W-1:0]      ch_child;
  logic [TAG_W-1:0]       ch_tag;
  logic [CNT_W-1:0]       srch_next;
  logic                   tree_full;
  logic                   list_full;
  logic                   idx_bad;

  assign new_node   = alloc[NODE_W-1:0];
  assign idx_node   = NODE_W'(idx_q);
  assign ch_child   = ch_rdata[NODE_W-1:0];
  assign ch_tag     = ch_rdata[NODE_W +: TAG_W];
  assign srch_next  = srch_i + CNT_W'(1);
  assign tree_full  = (alloc >= ALLOC_W'(MAX_NODES));
  assign list_full  = (n_q >= CNT_W'(MAX_CHILDREN));
  assign idx_bad    = (CMP_W'(idx_q) >= CMP_W'(alloc));
  assign item_stall = (state != S_IDLE);

  cctp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  cctp_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_total_ram (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(tot_raddr), .rdata(tot_rdata)
  );

  cctp_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_count_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  cctp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  cctp_ram #(.WIDTH(TAG_W), .DEPTH(MAX_NODES)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  // child slots hold {child tag, child index} so one read serves one compare
  cctp_ram #(.WIDTH(CH_W), .DEPTH(CH_DEPTH)) u_child_ram (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  always_comb begin
    tot_we    = 1'b0;
    tot_waddr = cur;
    tot_wdata = '0;
    tot_raddr = cur;
    cnt_we    = 1'b0;
    cnt_waddr = cur;
    cnt_wdata = '0;
    cnt_raddr = cur;
    par_we    = 1'b0;
    par_waddr = new_node;
    par_wdata = cur;
    par_raddr = cur;
    tag_we    = 1'b0;
    tag_waddr = new_node;
    tag_wdata = tag_q;
    tag_raddr = idx_node;
    ch_we     = 1'b0;
    ch_waddr  = {cur, n_q[SLOT_W-1:0]};
    ch_wdata  = {tag_q, new_node};
    ch_raddr  = {cur, srch_i[SLOT_W-1:0]};
    alu_req   = '{op: cctp_pkg::ALU_ADD, a: 32'd0, b: 32'd0};
    case (state)
      S_INIT, S_CLEAR: begin
        // root alone: zero total and child count of node 0
        tot_we    = 1'b1;
        tot_waddr = '0;
        cnt_we    = 1'b1;
        cnt_waddr = '0;
      end
      S_DELTA: begin
        alu_req = '{op: cctp_pkg::ALU_SUB, a: 32'(stamp_q), b: 32'(last_stamp)};
      end
      S_CHARGE: begin
        alu_req = '{op: cctp_pkg::ALU_ADD, a: total_q, b: 32'(delta_q)};
        tot_we    = 1'b1;
        tot_wdata = alu_rsp.res;
      end
      S_SEARCH: begin
        alu_req  = '{op: cctp_pkg::ALU_EQ, a: 32'(ch_tag), b: 32'(tag_q)};
        ch_raddr = {cur, srch_next[SLOT_W-1:0]};
      end
      S_ALLOC: begin
        if (!tree_full && !list_full) begin
          ch_we     = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = n_q + CNT_W'(1);
          par_we    = 1'b1;
          tag_we    = 1'b1;
          tot_we    = 1'b1;
          tot_waddr = new_node;
        end
      end
      S_ALLOC2: begin
        cnt_we    = 1'b1;
        cnt_waddr = new_node;
      end
      S_RD_ADDR: begin
        tot_raddr = idx_node;
        cnt_raddr = idx_node;
        par_raddr = idx_node;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cur          <= '0;
      alloc        <= ALLOC_W'(1);
      last_stamp   <= '0;
      result_valid <= 1'b0;
    end else begin
      // S_OUT drives result_valid itself
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            op_q       <= cctp_pkg::op_t'(operation);
            tag_q      <= tag[TAG_W-1:0];
            stamp_q    <= timestamp;
            idx_q      <= node_index;
            res_status <= cctp_pkg::ST_OK;
            res_total  <= '0;
            res_tag    <= '0;
            res_parent <= '0;
            res_count  <= '0;
            case (cctp_pkg::op_t'(operation))
              cctp_pkg::OP_READ:  state <= S_RD_ADDR;
              cctp_pkg::OP_CLEAR: state <= S_CLEAR;
              default:            state <= S_DELTA;
            endcase
          end
        end
        S_DELTA: begin
          delta_q    <= alu_rsp.res[15:0] & cctp_pkg::STAMP_MASK;
          total_q    <= tot_rdata;
          n_q        <= cnt_rdata;
          parent_q   <= par_rdata;
          last_stamp <= stamp_q;
          srch_i     <= '0;
          state      <= S_CHARGE;
        end
        S_CHARGE: begin
          if (op_q == cctp_pkg::OP_POP) begin
            if (cur == '0) begin
              res_status <= cctp_pkg::ST_POP_ROOT;
            end else begin
              cur <= parent_q;
            end
            state <= S_OUT;
          end else if (n_q == '0) begin
            state <= S_ALLOC;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (alu_rsp.eq) begin
            cur   <= ch_child;
            state <= S_OUT;
          end else if (srch_next >= n_q) begin
            state <= S_ALLOC;
          end else begin
            srch_i <= srch_next;
          end
        end
        S_ALLOC: begin
          if (tree_full) begin
            res_status <= cctp_pkg::ST_TREE_FULL;
            state      <= S_OUT;
          end else if (list_full) begin
            res_status <= cctp_pkg::ST_CHILDREN_FULL;
            state      <= S_OUT;
          end else begin
            state <= S_ALLOC2;
          end
        end
        S_ALLOC2: begin
          cur   <= new_node;
          alloc <= alloc + ALLOC_W'(1);
          state <= S_OUT;
        end
        S_RD_ADDR: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (idx_bad) begin
            res_status <= cctp_pkg::ST_BAD_INDEX;
          end else begin
            // root tag and parent are zero and never stored
            res_total  <= tot_rdata;
            res_tag    <= (idx_q == 6'd0) ? '0 : tag_rdata;
            res_parent <= (idx_q == 6'd0) ? '0 : par_rdata;
            res_count  <= cnt_rdata;
          end
          state <= S_OUT;
        end
        S_CLEAR: begin
          cur        <= '0;
          alloc      <= ALLOC_W'(1);
          last_stamp <= stamp_q;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid     <= 1'b1;
            current_node     <= 6'(cur);
            status           <= res_status;
            node_count       <= 7'(alloc);
            read_total       <= res_total;
            read_tag         <= 16'(res_tag);
            read_parent      <= 6'(res_parent);
            read_child_count <= 4'(res_count);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/cctp_ram.sv @@
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module cctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/cctp_alu.sv @@
// Shared 32-bit add / subtract / equality unit used by the profiler sequencer.
// Depends on cctp_pkg for the request and response structs.
module cctp_alu (
  input  cctp_pkg::alu_req_t req,
  output cctp_pkg::alu_rsp_t rsp
);

  always_comb begin
    rsp.eq  = (req.a == req.b);
    case (req.op)
      cctp_pkg::ALU_ADD: rsp.res = req.a + req.b;
      cctp_pkg::ALU_SUB: rsp.res = req.a - req.b;
      cctp_pkg::ALU_EQ:  rsp.res = 32'(req.a == req.b);
      default:           rsp.res = '0;
    endcase
  end

endmodule

@@ src/cctp_checker.sv @@
// Port-level checker for the call-context time profiler, bound to the top level.
// Depends on cctp_pkg for the status codes.
module cctp_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [5:0]  current_node,
  input logic [2:0]  status,
  input logic [31:0] read_total,
  input logic [15:0] read_tag,
  input logic [5:0]  read_parent,
  input logic [3:0]  read_child_count
);

  // one event at a time: input closes right after a transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after an event transfer");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= 3'(cctp_pkg::ST_BAD_INDEX))
    else $error("status code out of range");

  a_pop_root_stays: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == 3'(cctp_pkg::ST_POP_ROOT) |-> current_node == 6'd0)
    else $error("pop at root left the root");

  a_bad_read_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == 3'(cctp_pkg::ST_BAD_INDEX) |->
      read_total == 32'd0 && read_tag == 16'd0 && read_parent == 6'd0 &&
      read_child_count == 4'd0)
    else $error("unused-index read returned nonzero fields");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(status) && $stable(current_node) && $stable(read_total))
    else $error("stalled result changed");

endmodule

bind call_context_time_profiler cctp_checker u_cctp_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item_valid),
  .item_stall       (item_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .current_node     (current_node),
  .status           (status),
  .read_total       (read_total),
  .read_tag         (read_tag),
  .read_parent      (read_parent),
  .read_child_count (read_child_count)
);

@@ bench/call_context_time_profiler_test.sv @@
// Self-checking bench for call_context_time_profiler: queued event stimulus,
// bursty driver, stalling receiver, and an in-bench model of the context tree.
// Depends on cctp_pkg and the profiler RTL.
module call_context_time_profiler_test;

  localparam int NODE_LIMIT = 64;
  localparam int KID_LIMIT  = 8;

  typedef struct packed {
    logic [5:0]         current_node;
    cctp_pkg::status_t  status;
    logic [6:0]         node_count;
    logic [31:0]        read_total;
    logic [15:0]        read_tag;
    logic [5:0]         read_parent;
    logic [3:0]         read_child_count;
  } profile_result_t;

  typedef struct {
    cctp_pkg::op_t op;
    logic [15:0]   tag;
    logic [15:0]   stamp;
    logic [5:0]    idx;
    bit            drain_first;
  } profile_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  operation = 2'd0;
  logic [15:0] tag = 16'd0;
  logic [15:0] timestamp = 16'd0;
  logic [5:0]  node_index = 6'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [5:0]  current_node;
  logic [2:0]  status;
  logic [6:0]  node_count;
  logic [31:0] read_total;
  logic [15:0] read_tag;
  logic [5:0]  read_parent;
  logic [3:0]  read_child_count;

  call_context_time_profiler DUT (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .operation        (operation),
    .tag              (tag),
    .timestamp        (timestamp),
    .node_index       (node_index),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .current_node     (current_node),
    .status           (status),
    .node_count       (node_count),
    .read_total       (read_total),
    .read_tag         (read_tag),
    .read_parent      (read_parent),
    .read_child_count (read_child_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

  // Tree model
  logic [15:0] tree_tag       [NODE_LIMIT];
  logic [5:0]  tree_parent    [NODE_LIMIT];
  logic [5:0]  tree_kids      [NODE_LIMIT*KID_LIMIT];
  logic [3:0]  tree_kid_count [NODE_LIMIT];
  logic [31:0] tree_total     [NODE_LIMIT];
  logic [5:0]  cur_node;
  logic [6:0]  used_nodes;
  logic [15:0] prev_stamp;

  profile_event_t  pending_events[$];
  profile_result_t expected_results[$];
  profile_event_t  next_ev;
  profile_result_t got_result, want_result;

  int total_items = 0;
  int items_sent = 0;
  int results_seen = 0;
  int bad_results = 0;

  task automatic wipe_tree();
    int i;
    for (i = 0; i < NODE_LIMIT; i++) begin
      tree_tag[i] = '0;
      tree_parent[i] = '0;
      tree_kid_count[i] = '0;
      tree_total[i] = '0;
    end
    for (i = 0; i < NODE_LIMIT*KID_LIMIT; i++) tree_kids[i] = '0;
    cur_node = '0;
    used_nodes = 7'd1;
  endtask

  task automatic charge_ticks(input logic [15:0] ts);
    logic [15:0] d;
    d = ts - prev_stamp;
    tree_total[cur_node] = tree_total[cur_node] + {16'd0, d};
    prev_stamp = ts;
  endtask

  task automatic profile_event(input cctp_pkg::op_t op, input logic [15:0] tg,
                               input logic [15:0] ts, input logic [5:0] idx);
    profile_result_t r;
    logic [5:0] hit_node;
    logic [5:0] kid;
    logic [3:0] n;
    bit hit;
    int i;
    r = '0;
    r.status = cctp_pkg::ST_OK;
    case (op)
      cctp_pkg::OP_PUSH: begin
        n = tree_kid_count[cur_node];
        hit = 1'b0;
        hit_node = '0;
        for (i = 0; i < KID_LIMIT; i++) begin
          kid = tree_kids[cur_node*KID_LIMIT + i];
          if (!hit && i < n && tree_tag[kid] == tg) begin
            hit = 1'b1;
            hit_node = kid;
          end
        end
        charge_ticks(ts);
        if (hit) begin
          cur_node = hit_node;
        end else if (used_nodes >= NODE_LIMIT) begin
          r.status = cctp_pkg::ST_TREE_FULL;
        end else if (n >= KID_LIMIT) begin
          r.status = cctp_pkg::ST_CHILDREN_FULL;
        end else begin
          tree_kids[cur_node*KID_LIMIT + n] = used_nodes[5:0];
          tree_kid_count[cur_node] = n + 4'd1;
          tree_parent[used_nodes[5:0]] = cur_node;
          tree_tag[used_nodes[5:0]] = tg;
          tree_total[used_nodes[5:0]] = '0;
          tree_kid_count[used_nodes[5:0]] = '0;
          cur_node = used_nodes[5:0];
          used_nodes = used_nodes + 7'd1;
        end
      end
      cctp_pkg::OP_POP: begin
        charge_ticks(ts);
        if (cur_node == '0) r.status = cctp_pkg::ST_POP_ROOT;
        else cur_node = tree_parent[cur_node];
      end
      cctp_pkg::OP_READ: begin
        if ({1'b0, idx} >= used_nodes) begin
          r.status = cctp_pkg::ST_BAD_INDEX;
        end else begin
          r.read_total = tree_total[idx];
          r.read_tag = tree_tag[idx];
          r.read_parent = tree_parent[idx];
          r.read_child_count = tree_kid_count[idx];
        end
      end
      default: begin
        wipe_tree();
        prev_stamp = ts;
      end
    endcase
    r.current_node = cur_node;
    r.node_count = used_nodes;
    expected_results.push_back(r);
  endtask

  // Stimulus build
  logic [15:0] stamp_now = '0;
  logic [15:0] tag_pool [8];
  bit drain_next = 1'b0;

  task automatic queue_event(input cctp_pkg::op_t op, input logic [15:0] tg,
                             input logic [15:0] ts, input logic [5:0] idx);
    profile_event_t ev;
    ev.op = op;
    ev.tag = tg;
    ev.stamp = ts;
    ev.idx = idx;
    ev.drain_first = drain_next;
    drain_next = 1'b0;
    pending_events.push_back(ev);
  endtask

  task automatic queue_timed(input cctp_pkg::op_t op, input logic [15:0] tg,
                             input logic [5:0] idx);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) stamp_now = stamp_now;
    else if (r < 4) stamp_now = stamp_now + 16'($urandom);
    else stamp_now = stamp_now + 16'($urandom_range(0, 500));
    queue_event(op, tg, stamp_now, idx);
  endtask

  function automatic logic [15:0] pick_tag();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return tag_pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    int kind, len, k, r, depth;
    bit filled;
    logic [15:0] last_tag;
    wipe_tree();
    prev_stamp = '0;
    depth = 0;
    filled = 1'b0;
    for (k = 0; k < 8; k++) tag_pool[k] = 16'($urandom);

    // directed: reads at the index extremes, pop at root, stamp wrap, tag extremes
    queue_event(cctp_pkg::OP_READ, 16'h0000, 16'h0000, 6'd0);
    queue_event(cctp_pkg::OP_READ, 16'hffff, 16'hffff, 6'd63);
    queue_event(cctp_pkg::OP_POP,  16'h0000, 16'h0005, 6'd0);
    queue_event(cctp_pkg::OP_PUSH, 16'h0000, 16'hffff, 6'd0);
    queue_event(cctp_pkg::OP_PUSH, 16'hffff, 16'h0003, 6'd0);
    queue_event(cctp_pkg::OP_POP,  16'h0000, 16'h0010, 6'd0);
    queue_event(cctp_pkg::OP_PUSH, 16'hffff, 16'h0020, 6'd0);
    queue_event(cctp_pkg::OP_POP,  16'hffff, 16'h0021, 6'd0);
    queue_event(cctp_pkg::OP_POP,  16'h0000, 16'h0030, 6'd0);
    // fill the root's child list, then one more distinct tag
    stamp_now = 16'h0030;
    for (k = 0; k < 7; k++) begin
      queue_timed(cctp_pkg::OP_PUSH, 16'h0001 << k, 6'd0);
      queue_timed(cctp_pkg::OP_POP, 16'h0000, 6'd0);
    end
    queue_timed(cctp_pkg::OP_PUSH, 16'h8000, 6'd0);
    queue_timed(cctp_pkg::OP_READ, 16'h0000, 6'd0);
    queue_timed(cctp_pkg::OP_READ, 16'h0000, 6'd8);
    queue_timed(cctp_pkg::OP_READ, 16'h0000, 6'd2);
    queue_event(cctp_pkg::OP_CLEAR, 16'h5a5a, 16'habcd, 6'd42);
    queue_event(cctp_pkg::OP_READ, 16'h0000, 16'h0000, 6'd1);
    stamp_now = 16'habcd;

    drain_next = 1'b1;
    while (pending_events.size() < 440) begin
      if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
      if (!filled && pending_events.size() >= 250) begin
        // deep chain up to a full tree, then unwind past the root
        filled = 1'b1;
        queue_timed(cctp_pkg::OP_CLEAR, 16'($urandom), 6'($urandom));
        last_tag = '0;
        for (k = 0; k < NODE_LIMIT - 1; k++) begin
          last_tag = 16'($urandom);
          queue_timed(cctp_pkg::OP_PUSH, last_tag, 6'd0);
        end
        queue_timed(cctp_pkg::OP_PUSH, 16'($urandom), 6'd0);
        queue_timed(cctp_pkg::OP_PUSH, 16'($urandom), 6'd0);
        queue_timed(cctp_pkg::OP_POP, 16'h0000, 6'd0);
        queue_timed(cctp_pkg::OP_PUSH, last_tag, 6'd0);
        queue_timed(cctp_pkg::OP_READ, 16'h0000, 6'd63);
        queue_timed(cctp_pkg::OP_READ, 16'h0000, 6'd62);
        for (k = 0; k < NODE_LIMIT; k++) queue_timed(cctp_pkg::OP_POP, 16'h0000, 6'd0);
        depth = 0;
      end else begin
        kind = $urandom_range(0, 9);
        case (kind)
          6: begin
            len = $urandom_range(3, 12);
            for (k = 0; k < len; k++)
              queue_event(cctp_pkg::op_t'($urandom_range(0, 3)), 16'($urandom),
                          16'($urandom), 6'($urandom_range(0, 63)));
            depth = 0;
          end
          7: begin
            queue_timed(cctp_pkg::OP_CLEAR, 16'($urandom), 6'($urandom));
            depth = 0;
          end
          8: begin
            len = $urandom_range(8, 11);
            for (k = 0; k < len; k++) begin
              queue_timed(cctp_pkg::OP_PUSH, 16'($urandom), 6'd0);
              queue_timed(cctp_pkg::OP_POP, 16'h0000, 6'd0);
            end
          end
          9: begin
            len = $urandom_range(2, 5);
            for (k = 0; k < len; k++)
              queue_timed(cctp_pkg::OP_READ, 16'($urandom), 6'($urandom_range(0, 63)));
          end
          default: begin
            // nested calls over a small tag set so that pushes revisit nodes
            len = $urandom_range(6, 30);
            for (k = 0; k < len; k++) begin
              r = $urandom_range(0, 99);
              if (r < 45 && depth < 10) begin
                queue_timed(cctp_pkg::OP_PUSH, pick_tag(), 6'd0);
                depth++;
              end else if (r < 85 && depth > 0) begin
                queue_timed(cctp_pkg::OP_POP, 16'($urandom), 6'd0);
                depth--;
              end else if ($urandom_range(0, 3) == 0) begin
                queue_timed(cctp_pkg::OP_READ, 16'h0000, 6'($urandom_range(0, 63)));
              end else begin
                queue_timed(cctp_pkg::OP_READ, 16'h0000, 6'($urandom_range(0, 15)));
              end
            end
            while (depth > 0) begin
              queue_timed(cctp_pkg::OP_POP, 16'h0000, 6'd0);
              depth--;
            end
            if ($urandom_range(0, 3) == 0) queue_timed(cctp_pkg::OP_POP, 16'h0000, 6'd0);
          end
        endcase
      end
    end
    total_items = pending_events.size();
  end

  // Driver: bursts with random gaps; a flagged event waits for all results
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        profile_event(cctp_pkg::op_t'(operation), tag, timestamp, node_index);
        items_sent <= items_sent + 1;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_events.size() == 0 ||
                     (pending_events[0].drain_first &&
                      (item_valid || items_sent != results_seen))) begin
          item_valid <= 1'b0;
        end else begin
          next_ev = pending_events.pop_front();
          operation <= next_ev.op;
          tag <= next_ev.tag;
          timestamp <= next_ev.stamp;
          node_index <= next_ev.idx;
          item_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 23);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // Receiver: long hold-offs at fixed result counts
  int hold_left = 0;
  int next_hold_at = 80;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left <= 200;
      next_hold_at <= next_hold_at + 240;
    end
  end

  // Receiver: stall pattern switches among several modes
  int stall_mode = 0;
  int mode_timer = 0;
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (mode_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_timer = $urandom_range(20, 200);
    end else begin
      mode_timer--;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= (cycle_count % 5 < 2);
      endcase
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got_result.current_node = current_node;
      got_result.status = cctp_pkg::status_t'(status);
      got_result.node_count = node_count;
      got_result.read_total = read_total;
      got_result.read_tag = read_tag;
      got_result.read_parent = read_parent;
      got_result.read_child_count = read_child_count;
      if (results_seen >= items_sent) begin
        bad_results++;
        if (bad_results <= 10)
          $display("ERROR: result %0d transferred with no event pending", results_seen);
      end else begin
        want_result = expected_results.pop_front();
        if (got_result !== want_result) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display({"ERROR: result %0d expected node %0d status %0d count %0d",
                      " total %h tag %h parent %0d kids %0d"},
                     results_seen, want_result.current_node, want_result.status,
                     want_result.node_count, want_result.read_total, want_result.read_tag,
                     want_result.read_parent, want_result.read_child_count);
            $display("       actual node %0d status %0d count %0d total %h tag %h parent %0d kids %0d",
                     got_result.current_node, got_result.status, got_result.node_count,
                     got_result.read_total, got_result.read_tag, got_result.read_parent,
                     got_result.read_child_count);
          end
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    @(negedge rst);
    while (!(items_sent == total_items && results_seen == total_items)) @(posedge clk);
    repeat (40) @(posedge clk);
    if (bad_results == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
